// ===== hw/rtl/gamd_pkg.sv =====
// Shared types and constants for the grid axis mapping deriver.
`timescale 1ns / 1ps
`default_nettype none

package gamd_pkg;

    localparam int DEFAULT_INDEX_BITS = 12;

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REQUIRE_U_AXIS = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REQUIRE_V_AXIS = 1'd1;
    localparam int CFG_DATA_BITS = 1;

    localparam int SIGN_BITS = 2;
    localparam int RESULT_DATA_BITS = 4 * SIGN_BITS;

    typedef logic signed [SIGN_BITS-1:0] sign_t;

    localparam sign_t SIGN_ZERO = 2'sb00;
    localparam sign_t SIGN_POS  = 2'sb01;
    localparam sign_t SIGN_NEG  = 2'sb11;

    // B step per unit step along one A axis.
    typedef struct packed {
        sign_t dv;
        sign_t du;
    } axis_map_t;

    localparam axis_map_t MAP_NONE = '{dv: SIGN_ZERO, du: SIGN_ZERO};

    typedef struct packed {
        logic  axes_ok;
        sign_t v_to_dv;
        sign_t v_to_du;
        sign_t u_to_dv;
        sign_t u_to_du;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gamd_step.sv =====
// Per-word update of the axis maps and evaluation of the run result.
`timescale 1ns / 1ps
`default_nettype none

module gamd_step #(
    parameter int INDEX_BITS = gamd_pkg::DEFAULT_INDEX_BITS
) (
    input  wire logic                    require_u,
    input  wire logic                    require_v,
    input  wire logic                    awaiting_origin,
    input  wire logic [INDEX_BITS-1:0]   src_u,
    input  wire logic [INDEX_BITS-1:0]   src_v,
    input  wire logic [INDEX_BITS-1:0]   dst_u,
    input  wire logic [INDEX_BITS-1:0]   dst_v,
    input  wire logic [INDEX_BITS-1:0]   origin_src_u,
    input  wire logic [INDEX_BITS-1:0]   origin_src_v,
    input  wire logic [INDEX_BITS-1:0]   origin_dst_u,
    input  wire logic [INDEX_BITS-1:0]   origin_dst_v,
    input  wire gamd_pkg::axis_map_t     u_map,
    input  wire gamd_pkg::axis_map_t     v_map,
    output gamd_pkg::axis_map_t          u_map_work,
    output gamd_pkg::axis_map_t          v_map_work,
    output gamd_pkg::result_t            result
);
    import gamd_pkg::*;

    logic      du_zero;
    logic      dv_zero;
    logic      du_neg;
    logic      dv_neg;
    logic      bu_zero;
    logic      bv_zero;
    logic      bu_neg;
    logic      bv_neg;
    logic      along_bu;
    logic      along_bv;
    logic      fix_u;
    logic      fix_v;
    logic      found_u;
    logic      found_v;
    logic      same_axis;
    logic      ok;
    axis_map_t u_fixed;
    axis_map_t v_fixed;

    function automatic sign_t unit_sign(input logic neg);
        return neg ? SIGN_NEG : SIGN_POS;
    endfunction

    always_comb
    begin
        du_zero  = (src_u == origin_src_u);
        dv_zero  = (src_v == origin_src_v);
        du_neg   = (src_u < origin_src_u);
        dv_neg   = (src_v < origin_src_v);
        bu_zero  = (dst_u == origin_dst_u);
        bv_zero  = (dst_v == origin_dst_v);
        bu_neg   = (dst_u < origin_dst_u);
        bv_neg   = (dst_v < origin_dst_v);
        along_bu = bv_zero && !bu_zero;
        along_bv = bu_zero && !bv_zero;

        // The sign of the mapping is the product of the A and B step signs.
        u_fixed.du = along_bu ? unit_sign(du_neg ^ bu_neg) : SIGN_ZERO;
        u_fixed.dv = along_bv ? unit_sign(du_neg ^ bv_neg) : SIGN_ZERO;
        v_fixed.du = along_bu ? unit_sign(dv_neg ^ bu_neg) : SIGN_ZERO;
        v_fixed.dv = along_bv ? unit_sign(dv_neg ^ bv_neg) : SIGN_ZERO;

        fix_u = require_u && (u_map == MAP_NONE) && dv_zero && !du_zero;
        fix_v = require_v && (v_map == MAP_NONE) && du_zero && !dv_zero;

        if (awaiting_origin)
        begin
            u_map_work = MAP_NONE;
            v_map_work = MAP_NONE;
        end
        else
        begin
            u_map_work = fix_u ? u_fixed : u_map;
            v_map_work = fix_v ? v_fixed : v_map;
        end

        found_u = (u_map_work != MAP_NONE);
        found_v = (v_map_work != MAP_NONE);

        // Unit maps along one B axis each are orthogonal only on different axes.
        same_axis = ((u_map_work.du != SIGN_ZERO) && (v_map_work.du != SIGN_ZERO))
                 || ((u_map_work.dv != SIGN_ZERO) && (v_map_work.dv != SIGN_ZERO));

        ok = !(require_u && !found_u) && !(require_v && !found_v)
          && !(found_u && found_v && ((u_map_work == v_map_work) || same_axis));

        result.axes_ok = ok;
        result.u_to_du = ok ? u_map_work.du : SIGN_ZERO;
        result.u_to_dv = ok ? u_map_work.dv : SIGN_ZERO;
        result.v_to_du = ok ? v_map_work.du : SIGN_ZERO;
        result.v_to_dv = ok ? v_map_work.dv : SIGN_ZERO;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_axis_mapping_deriver_core.sv =====
// Top level of the grid axis mapping deriver: stream ports, registers and control.
`timescale 1ns / 1ps
`default_nettype none

// Takes a run of matched (u,v) grid index pairs, one word per cycle, and on the
// word marked with tlast delivers one result word with the success flag in tuser
// and the four mapping signs in tdata. Each input word passes an input register
// and compare logic against the stored origin, so the block accepts a word every
// cycle; the last word's result is held in a result register. The only
// back-pressure comes from the result register when a result is not yet taken.
module grid_axis_mapping_deriver_core #(
    parameter int INDEX_BITS = gamd_pkg::DEFAULT_INDEX_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // Fields from bit 0 up: src_u, src_v, dst_u, dst_v, zero padding.
    input  wire logic [((4*INDEX_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // Fields from bit 0 up: u_to_du, u_to_dv, v_to_du, v_to_dv.
    output logic [gamd_pkg::RESULT_DATA_BITS-1:0]      m_tdata,
    // Fields from bit 0 up: axes_ok.
    output logic                                       m_tuser,
    input  wire logic                                  cfg_we,
    input  wire logic [gamd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire logic [gamd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import gamd_pkg::*;

    logic                  require_u_reg;
    logic                  require_v_reg;

    logic                  in_valid_reg;
    logic                  in_last_reg;
    logic [INDEX_BITS-1:0] in_src_u_reg;
    logic [INDEX_BITS-1:0] in_src_v_reg;
    logic [INDEX_BITS-1:0] in_dst_u_reg;
    logic [INDEX_BITS-1:0] in_dst_v_reg;

    logic                  awaiting_reg;
    logic [INDEX_BITS-1:0] origin_src_u_reg;
    logic [INDEX_BITS-1:0] origin_src_v_reg;
    logic [INDEX_BITS-1:0] origin_dst_u_reg;
    logic [INDEX_BITS-1:0] origin_dst_v_reg;
    axis_map_t             u_map_reg;
    axis_map_t             v_map_reg;
    axis_map_t             u_map_next;
    axis_map_t             v_map_next;

    logic                  out_valid_reg;
    result_t               out_result_reg;

    axis_map_t             u_map_work;
    axis_map_t             v_map_work;
    result_t               step_result;
    logic                  out_free;
    logic                  stage_go;
    logic                  s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign stage_go = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || stage_go;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.axes_ok;
    assign m_tdata  = {out_result_reg.v_to_dv, out_result_reg.v_to_du,
                       out_result_reg.u_to_dv, out_result_reg.u_to_du};

    assign u_map_next = in_last_reg ? MAP_NONE : u_map_work;
    assign v_map_next = in_last_reg ? MAP_NONE : v_map_work;

    gamd_step #(
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .require_u       (require_u_reg),
        .require_v       (require_v_reg),
        .awaiting_origin (awaiting_reg),
        .src_u           (in_src_u_reg),
        .src_v           (in_src_v_reg),
        .dst_u           (in_dst_u_reg),
        .dst_v           (in_dst_v_reg),
        .origin_src_u    (origin_src_u_reg),
        .origin_src_v    (origin_src_v_reg),
        .origin_dst_u    (origin_dst_u_reg),
        .origin_dst_v    (origin_dst_v_reg),
        .u_map           (u_map_reg),
        .v_map           (v_map_reg),
        .u_map_work      (u_map_work),
        .v_map_work      (v_map_work),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_u_reg <= 1'b1;
            require_v_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_REQUIRE_U_AXIS: require_u_reg <= cfg_wdata[0];
                REG_REQUIRE_V_AXIS: require_v_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_last_reg  <= s_tlast;
            in_src_u_reg <= s_tdata[0*INDEX_BITS +: INDEX_BITS];
            in_src_v_reg <= s_tdata[1*INDEX_BITS +: INDEX_BITS];
            in_dst_u_reg <= s_tdata[2*INDEX_BITS +: INDEX_BITS];
            in_dst_v_reg <= s_tdata[3*INDEX_BITS +: INDEX_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            u_map_reg    <= MAP_NONE;
            v_map_reg    <= MAP_NONE;
        end
        else if (stage_go)
        begin
            awaiting_reg <= in_last_reg;
            u_map_reg    <= u_map_next;
            v_map_reg    <= v_map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && awaiting_reg)
        begin
            origin_src_u_reg <= in_src_u_reg;
            origin_src_v_reg <= in_src_v_reg;
            origin_dst_u_reg <= in_dst_u_reg;
            origin_dst_v_reg <= in_dst_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && in_last_reg)
        begin
            out_result_reg <= step_result;
        end
    end

    // A processed last word always rearms the origin capture and posts a result.
    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && in_last_reg) |=> (awaiting_reg && out_valid_reg))
        else $error("last word did not rearm origin capture or post a result");

    // While waiting for an origin, no axis map may be held.
    a_idle_maps_clear: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> ((u_map_reg == MAP_NONE) && (v_map_reg == MAP_NONE)))
        else $error("axis map held while waiting for a new origin");

    // A failed result carries no mapping signs.
    a_fail_signs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed result carries nonzero mapping signs");

    // A successful result never maps both A axes onto B u.
    a_ok_orthogonal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser && (out_result_reg.u_to_du != SIGN_ZERO)
            && (out_result_reg.v_to_du != SIGN_ZERO)) |-> 1'b0)
        else $error("successful result maps both A axes onto B u");

    // Each stored axis map runs along at most one B axis.
    a_map_single_axis: assert property (@(posedge clk) disable iff (!rst_n)
        !((u_map_reg.du != SIGN_ZERO) && (u_map_reg.dv != SIGN_ZERO))
        && !((v_map_reg.du != SIGN_ZERO) && (v_map_reg.dv != SIGN_ZERO)))
        else $error("axis map runs along both B axes");

endmodule

`default_nettype wire
